// File: rtl/core/hdtu_pkg.sv
package hdtu_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_EDGE  = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_START = 2'd3
  } cmd_e;

  localparam logic [3:0] RX_IDLE_PHASE = 4'd9;
  localparam logic [3:0] TX_STOP_BIT   = 4'd9;
  localparam logic [7:0] LINE_FEED     = 8'h0A;

  typedef struct packed {
    cmd_e       command;
    logic       rx_level;
    logic [3:0] tx_index;
    logic [7:0] tx_byte;
    logic [4:0] tx_length;
  } in_t;

  typedef struct packed {
    logic       txd_level;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_line_end;
    logic       tx_busy;
    logic       rx_active;
  } out_t;

  typedef struct packed {
    logic busy_q;
    logic busy_d;
    logic line_d;
  } tx_stat_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       line_end;
    logic       active;
  } rx_stat_t;

endpackage

// File: rtl/core/hdtu_ram.sv
module hdtu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // write-first on a same-address collision
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/hdtu_tx.sv
module hdtu_tx #(
  parameter int unsigned MSG_BYTES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  hdtu_pkg::in_t    req_i,
  output hdtu_pkg::tx_stat_t stat_o
);

  import hdtu_pkg::*;

  localparam int unsigned AW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam logic [4:0] LEN_MAX = 5'((MSG_BYTES > 31) ? 31 : MSG_BYTES);

  logic [7:0]    shift_q, shift_d;
  logic [3:0]    bit_cnt_q, bit_cnt_d;
  logic [4:0]    pos_q, pos_d;
  logic [4:0]    count_q, count_d;
  logic          sending_q, sending_d;
  logic          line_q, line_d;

  logic [3:0]    bit_nxt;
  logic [4:0]    pos_nxt;
  logic [4:0]    len;
  logic [4:0]    pos_ahead;
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign bit_nxt   = bit_cnt_q + 4'd1;
  assign pos_nxt   = pos_q + 5'd1;
  assign pos_ahead = pos_d + 5'd1;

  always_comb begin
    len = (req_i.tx_length == 5'd0) ? 5'd1 : req_i.tx_length;
    if (len > LEN_MAX) begin
      len = LEN_MAX;
    end
  end

  always_comb begin
    shift_d   = shift_q;
    bit_cnt_d = bit_cnt_q;
    pos_d     = pos_q;
    count_d   = count_q;
    sending_d = sending_q;
    line_d    = line_q;
    if (fire_i) begin
      case (req_i.command)
        CMD_TICK: begin
          if (sending_q) begin
            bit_cnt_d = bit_nxt;
            if (bit_nxt >= 4'd1 && bit_nxt <= 4'd8) begin
              line_d  = shift_q[0];
              shift_d = shift_q >> 1;
            end else if (bit_nxt == TX_STOP_BIT) begin
              line_d = 1'b1;
            end else begin
              pos_d     = pos_nxt;
              bit_cnt_d = 4'd0;
              if (pos_nxt < count_q) begin
                shift_d = ram_rdata;
                line_d  = 1'b0;
              end else begin
                sending_d = 1'b0;
                line_d    = 1'b1;
              end
            end
          end
        end
        CMD_START: begin
          if (!sending_q) begin
            count_d   = len;
            pos_d     = 5'd0;
            bit_cnt_d = 4'd0;
            shift_d   = ram_rdata;
            sending_d = 1'b1;
            line_d    = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // read data always tracks the byte needed after the next state
  assign ram_raddr = sending_d ? AW'(pos_ahead) : '0;
  assign ram_we    = fire_i && (req_i.command == CMD_LOAD) && !sending_q &&
                     (32'(req_i.tx_index) < 32'(MSG_BYTES));

  hdtu_ram #(
    .WIDTH(8),
    .DEPTH(MSG_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(req_i.tx_index)),
    .wdata_i(req_i.tx_byte),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q   <= 8'd0;
      bit_cnt_q <= 4'd0;
      pos_q     <= 5'd0;
      count_q   <= 5'd0;
      sending_q <= 1'b0;
      line_q    <= 1'b1;
    end else begin
      shift_q   <= shift_d;
      bit_cnt_q <= bit_cnt_d;
      pos_q     <= pos_d;
      count_q   <= count_d;
      sending_q <= sending_d;
      line_q    <= line_d;
    end
  end

  assign stat_o.busy_q = sending_q;
  assign stat_o.busy_d = sending_d;
  assign stat_o.line_d = line_d;

endmodule

// File: rtl/core/hdtu_rx.sv
module hdtu_rx (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  hdtu_pkg::in_t      req_i,
  input  logic               tx_busy_i,
  output hdtu_pkg::rx_stat_t stat_o
);

  import hdtu_pkg::*;

  logic [3:0] phase_q, phase_d;
  logic [7:0] shift_q, shift_d;
  logic [3:0] phase_nxt;
  logic [2:0] bit_idx;
  logic       done;

  assign phase_nxt = phase_q + 4'd1;
  assign bit_idx   = 3'(phase_nxt - 4'd1);

  always_comb begin
    phase_d = phase_q;
    shift_d = shift_q;
    done    = 1'b0;
    if (fire_i && !tx_busy_i) begin
      case (req_i.command)
        CMD_TICK: begin
          if (phase_q < RX_IDLE_PHASE) begin
            phase_d = phase_nxt;
            if (phase_nxt == RX_IDLE_PHASE) begin
              done = 1'b1;
            end else begin
              shift_d[bit_idx] = req_i.rx_level;
            end
          end
        end
        CMD_EDGE: begin
          if (!req_i.rx_level && phase_q >= RX_IDLE_PHASE) begin
            phase_d = 4'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= RX_IDLE_PHASE;
      shift_q <= 8'd0;
    end else begin
      phase_q <= phase_d;
      shift_q <= shift_d;
    end
  end

  assign stat_o.valid    = done;
  assign stat_o.data     = done ? shift_q : 8'd0;
  assign stat_o.line_end = done && (shift_q == LINE_FEED);
  assign stat_o.active   = phase_d < RX_IDLE_PHASE;

endmodule

// File: rtl/core/half_duplex_tick_uart_top.sv
// Channel  | Valid       | Ready       | Request
// ---------+-------------+-------------+-----------------------
// input    | in_valid_i  | in_ready_o  | in_req_i  (in_t)
// output   | out_valid_o | out_ready_i | out_req_o (out_t)
//
// One request per cycle while in_ready_o is high; each gives one result, registered in the cycle after acceptance.
// All state updates are one pass of logic into registers; the message store
// is a RAM with a registered read, addressed ahead of the byte it serves.
// in_ready_o is high while the result register is empty or being drained.
// Reset: line idle high, receiver idle, store contents undefined until loaded.
module half_duplex_tick_uart_top #(
  parameter int unsigned MSG_BYTES = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hdtu_pkg::in_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hdtu_pkg::out_t out_req_o
);

  import hdtu_pkg::*;

  logic     fire;
  tx_stat_t tx_stat;
  rx_stat_t rx_stat;
  logic     out_valid_q;
  out_t     out_q, out_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  hdtu_tx #(
    .MSG_BYTES(MSG_BYTES)
  ) u_tx (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .req_i (in_req_i),
    .stat_o(tx_stat)
  );

  hdtu_rx u_rx (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .req_i    (in_req_i),
    .tx_busy_i(tx_stat.busy_q),
    .stat_o   (rx_stat)
  );

  always_comb begin
    out_d.txd_level   = tx_stat.line_d;
    out_d.rx_valid    = rx_stat.valid;
    out_d.rx_byte     = rx_stat.data;
    out_d.rx_line_end = rx_stat.line_end;
    out_d.tx_busy     = tx_stat.busy_d;
    out_d.rx_active   = rx_stat.active;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  a_rx_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.rx_valid |-> !out_req_o.tx_busy && !out_req_o.rx_active)
    else $error("rx byte completed while busy");

  a_start_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_req_i.command == CMD_START) && !tx_stat.busy_q
      |=> out_req_o.tx_busy && !out_req_o.txd_level)
    else $error("start did not drive start bit");

  a_idle_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_req_o.tx_busy |-> out_req_o.txd_level)
    else $error("line low while transmitter idle");

endmodule
